// File: src/lpml_pkg.sv
// ----------------------------------------------------------------------------
// lpml_pkg: shared types and constants of the route lookup unit
// Field widths, command codes, the queue item and the stored route entry.
// ----------------------------------------------------------------------------
package lpml_pkg;

    localparam int ADDR_W            = 32;
    localparam int INDEX_W           = 5;
    localparam int LEN_W             = 6;
    localparam int MAX_SLOTS         = 1 << INDEX_W;
    localparam int ROUTE_ENTRIES_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = 1;
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // One queued transaction, classified by the front end.
    typedef struct packed {
        t_op                 op;
        logic [INDEX_W-1:0]  entry_index;
        logic [ADDR_W-1:0]   route_prefix;
        logic [ADDR_W-1:0]   route_mask;
        logic [LEN_W-1:0]    mask_len;
        logic                entry_valid;
        logic [ADDR_W-1:0]   lookup_addr;
    } t_item;

    // One route entry as held in the table memory.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // Population count as a five-level adder tree.
    function automatic logic [LEN_W-1:0] popcount32(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] s1;
        logic [ADDR_W-1:0] s2;
        logic [ADDR_W-1:0] s3;
        logic [ADDR_W-1:0] s4;
        logic [ADDR_W-1:0] s5;
        s1 = (v  & 32'h5555_5555) + ((v  >> 1)  & 32'h5555_5555);
        s2 = (s1 & 32'h3333_3333) + ((s1 >> 2)  & 32'h3333_3333);
        s3 = (s2 & 32'h0F0F_0F0F) + ((s2 >> 4)  & 32'h0F0F_0F0F);
        s4 = (s3 & 32'h00FF_00FF) + ((s3 >> 8)  & 32'h00FF_00FF);
        s5 = (s4 & 32'h0000_FFFF) + ((s4 >> 16) & 32'h0000_FFFF);
        return s5[LEN_W-1:0];
    endfunction

endpackage

// File: src/lpml_ram.sv
// ----------------------------------------------------------------------------
// lpml_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lpml_front.sv
// ----------------------------------------------------------------------------
// lpml_front: input acceptance and classification
// Accept transactions while the queue has room, drop out-of-range writes,
// precompute the mask length of writes and push the rest into the queue.
// ----------------------------------------------------------------------------
module lpml_front #(
    parameter int DEPTH = lpml_pkg::MAX_SLOTS
) (
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [lpml_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [lpml_pkg::ADDR_W-1:0]       i_route_prefix,
    input  logic [lpml_pkg::ADDR_W-1:0]       i_route_mask,
    input  logic                              i_entry_valid,
    input  logic [lpml_pkg::ADDR_W-1:0]       i_lookup_addr,
    input  lpml_pkg::t_q_status               i_q_status,
    output logic                              o_push,
    output lpml_pkg::t_item                   o_item
);

    logic w_keep;
    logic w_accept;

    assign o_stall  = i_q_status.full;
    assign w_accept = i_valid && !i_q_status.full;

    always_comb begin
        w_keep = 1'b1;
        unique case (lpml_pkg::t_op'(i_cmd))
            lpml_pkg::OP_WRITE:  w_keep = (int'(i_entry_index) < DEPTH);
            lpml_pkg::OP_LOOKUP: w_keep = 1'b1;
            default:             w_keep = 1'b1;
        endcase
    end

    assign o_push = w_accept && w_keep;

    always_comb begin
        o_item.op           = lpml_pkg::t_op'(i_cmd);
        o_item.entry_index  = i_entry_index;
        o_item.route_prefix = i_route_prefix;
        o_item.route_mask   = i_route_mask;
        o_item.mask_len     = lpml_pkg::popcount32(i_route_mask);
        o_item.entry_valid  = i_entry_valid;
        o_item.lookup_addr  = i_lookup_addr;
    end

endmodule

// File: src/lpml_queue.sv
// ----------------------------------------------------------------------------
// lpml_queue: short FIFO between front end and lookup engine
// Holds classified transactions so each side can stall on its own.
// ----------------------------------------------------------------------------
module lpml_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lpml_pkg::t_item       i_item,
    input  logic                  i_pop,
    output lpml_pkg::t_item       o_head,
    output lpml_pkg::t_q_status   o_status
);

    lpml_pkg::t_item                  r_mem [lpml_pkg::QUEUE_DEPTH];
    logic [lpml_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [lpml_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [lpml_pkg::QCNT_W-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == lpml_pkg::QCNT_W'(lpml_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

// File: src/lpml_back.sv
// ----------------------------------------------------------------------------
// lpml_back: route table and sequential match engine
// Apply writes to the table, scan the table one entry per cycle for lookups
// and hold the best match in an output register.
// ----------------------------------------------------------------------------
module lpml_back #(
    parameter int DEPTH = lpml_pkg::MAX_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lpml_pkg::t_item                i_item,
    input  lpml_pkg::t_q_status            i_q_status,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [lpml_pkg::INDEX_W-1:0]   o_match_index,
    output logic [lpml_pkg::LEN_W-1:0]     o_prefix_len
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(lpml_pkg::t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state                          r_state;
    logic [DEPTH-1:0]                r_valid;
    logic [CW-1:0]                   r_cnt;
    logic                            r_cmp_vld;
    logic [IW-1:0]                   r_cmp_idx;
    logic [lpml_pkg::ADDR_W-1:0]     r_addr;
    logic                            r_found;
    logic [IW-1:0]                   r_best_idx;
    logic [lpml_pkg::LEN_W-1:0]      r_best_len;
    logic                            r_out_vld;
    logic                            r_hit;
    logic [lpml_pkg::INDEX_W-1:0]    r_idx_out;
    logic [lpml_pkg::LEN_W-1:0]      r_len_out;

    logic                            w_issue;
    logic                            w_we;
    logic [IW-1:0]                   w_widx;
    lpml_pkg::t_entry                w_wentry;
    logic [EW-1:0]                   w_rdata;
    lpml_pkg::t_entry                w_rentry;
    logic                            w_match;
    logic                            w_better;
    logic                            w_load;

    assign o_pop   = (r_state == S_IDLE) && !i_q_status.empty;
    assign w_we    = o_pop && (i_item.op == lpml_pkg::OP_WRITE);
    assign w_widx  = i_item.entry_index[IW-1:0];
    assign w_issue = (r_state == S_SCAN) && (r_cnt < CW'(DEPTH));
    // load the output register once it is free or being drained
    assign w_load  = (r_state == S_RESULT) && (!r_out_vld || !i_stall);

    always_comb begin
        w_wentry.prefix = i_item.route_prefix;
        w_wentry.mask   = i_item.route_mask;
        w_wentry.len    = i_item.mask_len;
    end

    lpml_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_widx),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rentry = lpml_pkg::t_entry'(w_rdata);
    assign w_match  = r_cmp_vld && r_valid[r_cmp_idx] &&
                      ((r_addr & w_rentry.mask) == w_rentry.prefix);
    // strictly longer wins, so the lowest slot keeps a tie
    assign w_better = w_match && (!r_found || (w_rentry.len > r_best_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        if (i_item.op == lpml_pkg::OP_WRITE) begin
                            r_valid[w_widx] <= i_item.entry_valid;
                        end else begin
                            r_addr    <= i_item.lookup_addr;
                            r_cnt     <= '0;
                            r_cmp_vld <= 1'b0;
                            r_found   <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= w_issue;
                    r_cmp_idx <= r_cnt[IW-1:0];
                    if (w_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_better) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_cmp_idx;
                        r_best_len <= w_rentry.len;
                    end
                    if (r_cnt == CW'(DEPTH)) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_load) begin
                        r_hit     <= r_found;
                        r_idx_out <= r_found ? lpml_pkg::INDEX_W'(r_best_idx) : '0;
                        r_len_out <= r_found ? r_best_len : '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_vld;
    assign o_hit         = r_hit;
    assign o_match_index = r_idx_out;
    assign o_prefix_len  = r_len_out;

endmodule

// File: src/longest_prefix_match_lookup_unit.sv
// ----------------------------------------------------------------------------
// longest_prefix_match_lookup_unit: IPv4 longest-prefix-match route engine
//
// Input channel (i_valid / o_stall) carries write and lookup transactions.
// A write (i_cmd = 0) stores prefix, mask and valid at i_entry_index and
// produces no result; a write to a slot at or above ROUTE_ENTRIES is dropped.
// A lookup (i_cmd = 1) produces exactly one result transaction on the output
// channel (o_valid / i_stall): hit, index of the best match and its mask bit
// count. The longest mask wins, the lowest slot wins a tie; without a hit
// the index and length read zero.
// A two-entry queue parts the front end from the lookup engine, so new
// transactions are taken while a lookup runs or a result waits.
// The engine takes one transaction at a time from the queue: a write is applied
// as it is taken, while a lookup holds the engine for a full table scan
// (DEPTH = ROUTE_ENTRIES capped at 32) through the table memory's single read
// port, one entry per cycle. A lookup reaches o_valid through the queue, the
// table scan and the output register. A stalled result holds in the output
// register; the engine finishes the next lookup and waits before loading its result.
// Reset (synchronous, active low) marks every table entry invalid and
// empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module longest_prefix_match_lookup_unit #(
    parameter int ROUTE_ENTRIES = lpml_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [lpml_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [lpml_pkg::ADDR_W-1:0]    i_route_prefix,
    input  logic [lpml_pkg::ADDR_W-1:0]    i_route_mask,
    input  logic                           i_entry_valid,
    input  logic [lpml_pkg::ADDR_W-1:0]    i_lookup_addr,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [lpml_pkg::INDEX_W-1:0]   o_match_index,
    output logic [lpml_pkg::LEN_W-1:0]     o_prefix_len
);

    // Only slots reachable by the 5-bit index can ever hold a route.
    localparam int DEPTH = (ROUTE_ENTRIES < lpml_pkg::MAX_SLOTS) ?
                           ROUTE_ENTRIES : lpml_pkg::MAX_SLOTS;

    logic                  w_push;
    logic                  w_pop;
    lpml_pkg::t_item       w_push_item;
    lpml_pkg::t_item       w_head;
    lpml_pkg::t_q_status   w_q_status;

    // Front end: accept, drop out-of-range writes, count mask bits.
    lpml_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_route_prefix (i_route_prefix),
        .i_route_mask   (i_route_mask),
        .i_entry_valid  (i_entry_valid),
        .i_lookup_addr  (i_lookup_addr),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    // Queue: decouple acceptance from the table scan.
    lpml_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Back end: apply writes, scan the table for lookups, hold the result.
    lpml_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_match_index (o_match_index),
        .o_prefix_len  (o_prefix_len)
    );

    // A miss reports zero index and zero length.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_match_index == '0 && o_prefix_len == '0))
        else $error("miss result carries nonzero fields");

    // A reported length never exceeds the address width.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_prefix_len <= lpml_pkg::LEN_W'(lpml_pkg::ADDR_W)))
        else $error("prefix length out of range");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= lpml_pkg::QCNT_W'(lpml_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

    // Nothing is popped from an empty queue.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

endmodule
